[design/layer_mac_accumulator_core_macros.svh]
// assertion macros for the layer mac accumulator
// expects clk and rst in the scope where a macro is used
`ifndef LAYER_MAC_ACCUMULATOR_CORE_MACROS_SVH
`define LAYER_MAC_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication
`define LMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("layer mac accumulator assertion failed");

// next-cycle implication
`define LMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("layer mac accumulator assertion failed");

`endif

[design/lma_pkg.sv]
// shared types and codes for the layer mac accumulator
// no dependencies
`default_nettype none

package lma_pkg;

  localparam logic [2:0] MODE_CLEAR    = 3'd0;
  localparam logic [2:0] MODE_SET_BIAS = 3'd1;
  localparam logic [2:0] MODE_ADD_BIAS = 3'd2;
  localparam logic [2:0] MODE_ACCUM    = 3'd3;
  localparam logic [2:0] MODE_READ     = 3'd4;

  localparam logic REG_OMIT_MASK  = 1'b0;
  localparam logic REG_OFFSET_EN  = 1'b1;

  localparam int SumWidth = 40;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         dest_index;
    logic signed [15:0] source_value;
    logic signed [15:0] source_offset;
    logic signed [15:0] weight;
    logic [15:0]        omit_flags;
  } cmd_t;

  typedef struct packed {
    logic signed [39:0] unit_sum;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [15:0] omit_mask;
    logic        offset_enable;
  } cfg_t;

endpackage

`default_nettype wire

[design/lma_cfg_regs.sv]
// apb configuration registers: omit mask and offset enable
// uses lma_pkg
`default_nettype none

module lma_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lma_pkg::cfg_t     cfg
);

  logic reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.omit_mask     <= '0;
      cfg.offset_enable <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        lma_pkg::REG_OMIT_MASK: cfg.omit_mask     <= pwdata[15:0];
        lma_pkg::REG_OFFSET_EN: cfg.offset_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lma_pkg::REG_OMIT_MASK: prdata = {16'b0, cfg.omit_mask};
      lma_pkg::REG_OFFSET_EN: prdata = {31'b0, cfg.offset_enable};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[design/lma_sum_mem.sv]
// unit sum store: one write port, one read port, registered read data
// no dependencies
`default_nettype none

module lma_sum_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int WIDTH = 40
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/lma_mac_unit.sv]
// read-modify-write datapath: decode and multiply, then add, clamp and write back
// uses lma_pkg
`default_nettype none

module lma_mac_unit #(
  parameter int MAX_UNITS = 256,
  parameter int AW        = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire lma_pkg::cmd_t   cmd,
  input  wire lma_pkg::cfg_t   cfg,
  output logic                 busy,
  output logic                 mem_re,
  output logic [AW-1:0]        mem_raddr,
  input  wire logic [39:0]     mem_rdata,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [39:0]          mem_wdata,
  output logic                 done,
  output lma_pkg::result_t     result
);

  localparam logic [12:0] UnitLimit = 13'(MAX_UNITS);

  logic               accept;
  logic               in_range;
  logic               omitted;
  logic signed [16:0] src;
  logic signed [32:0] product;
  logic signed [32:0] bias;

  logic               s1_valid;
  logic [2:0]         s1_mode;
  logic [AW-1:0]      s1_addr;
  logic               s1_ok;
  logic               s1_skip;
  logic signed [32:0] s1_addend;

  logic               sat;
  logic signed [40:0] sum_wide;
  logic               ovf;
  logic signed [39:0] sum_clamped;

  assign accept    = start && !busy;
  assign busy      = s1_valid;
  assign in_range  = {5'b0, cmd.dest_index} < UnitLimit;
  assign omitted   = (cmd.omit_flags & cfg.omit_mask) != 16'b0;
  assign src       = cfg.offset_enable ? (17'(cmd.source_value) + 17'(cmd.source_offset))
                                       : 17'(cmd.source_value);
  assign product   = src * cmd.weight;
  assign bias      = {{5{cmd.weight[15]}}, cmd.weight, 12'b0};
  assign mem_re    = accept;
  assign mem_raddr = AW'(cmd.dest_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode   <= cmd.mode;
      s1_addr   <= AW'(cmd.dest_index);
      s1_ok     <= in_range;
      s1_skip   <= omitted;
      s1_addend <= (cmd.mode == lma_pkg::MODE_ACCUM) ? product : bias;
    end
  end

  assign sum_wide    = 41'(signed'(mem_rdata)) + 41'(s1_addend);
  assign ovf         = sum_wide[40] != sum_wide[39];
  assign sum_clamped = !ovf ? sum_wide[39:0]
                     : (sum_wide[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}});

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = sum_clamped;
    case (s1_mode)
      lma_pkg::MODE_CLEAR: begin
        mem_we    = s1_valid && s1_ok;
        mem_wdata = '0;
      end
      lma_pkg::MODE_SET_BIAS: begin
        mem_we    = s1_valid && s1_ok;
        mem_wdata = 40'(s1_addend);
      end
      lma_pkg::MODE_ADD_BIAS: mem_we = s1_valid && s1_ok;
      lma_pkg::MODE_ACCUM:    mem_we = s1_valid && s1_ok && !s1_skip;
      default:                mem_we = 1'b0;
    endcase
  end

  assign mem_waddr = s1_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (mem_we && ovf &&
          (s1_mode == lma_pkg::MODE_ADD_BIAS || s1_mode == lma_pkg::MODE_ACCUM)) begin
        sat <= 1'b1;
      end
      done <= s1_valid && (s1_mode == lma_pkg::MODE_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      result.unit_sum  <= s1_ok ? mem_rdata : '0;
      result.saturated <= sat;
    end
  end

endmodule

`default_nettype wire

[design/layer_mac_accumulator_core.sv]
// layer mac accumulator: per-unit Q16.24 summed inputs for one dense layer
//
// commands enter on cmd when start is high and busy is low; each transaction
// clears, sets a bias, adds a bias, accumulates one weighted connection, or
// reads one unit's sum. the sums live in a MAX_UNITS x 40 synchronous memory.
// a transaction reads its entry at acceptance, then adds, clamps and writes
// back in the following cycle, during which busy is high.
// a new command is refused while busy is high, so the block cannot take one
// before the read-modify-write of the last one on the single sum store is done.
// a read result appears on result with done high for one cycle, registered from
// the write-back stage; other modes give no result. the receiver cannot
// stall, the result is taken in that cycle.
// saturated reports whether any add-bias or accumulate clamped since reset.
// reset clears the sticky flag and both config registers; the sum store is
// not cleared, so every unit must be cleared or set before it is read.
// config: apb at byte 0 (omit mask) and byte 4 (offset enable); the user must
// write it only while idle, which the block itself does not enforce.
// uses lma_pkg, lma_cfg_regs, lma_sum_mem, lma_mac_unit
`default_nettype none

`include "layer_mac_accumulator_core_macros.svh"

module layer_mac_accumulator_core #(
  parameter int MAX_UNITS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire lma_pkg::cmd_t cmd,
  output logic               done,
  output lma_pkg::result_t   result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

  lma_pkg::cfg_t cfg;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [39:0]   mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [39:0]   mem_wdata;

  lma_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lma_sum_mem #(
    .DEPTH (MAX_UNITS),
    .AW    (AW),
    .WIDTH (lma_pkg::SumWidth)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lma_mac_unit #(
    .MAX_UNITS (MAX_UNITS),
    .AW        (AW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg       (cfg),
    .busy      (busy),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .done      (done),
    .result    (result)
  );

  `LMA_ASSERT_NXT(a_accept_sets_busy, start && !busy, busy)
  `LMA_ASSERT_NXT(a_busy_one_cycle, busy, !busy)
  `LMA_ASSERT_IMP(a_done_after_busy, done, $past(busy))
  `LMA_ASSERT_IMP(a_write_only_busy, mem_we, busy && !mem_re)

endmodule

`default_nettype wire

[dv/lma_sum_checker.sv]
// checker for the layer mac accumulator: follows commands, apb writes and read results,
// keeps its own copy of the unit sums and compares every read transaction
// depends on lma_pkg
`timescale 1ns / 1ps

module lma_sum_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  lma_pkg::cmd_t     cmd,
  input  logic              done,
  input  lma_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                errors,
  output int                pending,
  output int                reads_checked
);

  localparam logic [2:0] ADDR_OMIT_MASK = {lma_pkg::REG_OMIT_MASK, 2'b00};
  localparam logic [2:0] ADDR_OFFSET_EN = {lma_pkg::REG_OFFSET_EN, 2'b00};
  localparam longint SUM_HI = (longint'(1) <<< 39) - 1;
  localparam longint SUM_LO = -(longint'(1) <<< 39);

  logic signed [39:0] unit_sum_q [256];
  logic               sat_seen;
  logic [15:0]        omit_mask_q;
  logic               offset_en_q;
  lma_pkg::result_t   reads_due [$];

  function automatic logic signed [39:0] clamp_sum(input longint x);
    if (x > SUM_HI) begin
      sat_seen = 1'b1;
      return 40'(SUM_HI);
    end
    if (x < SUM_LO) begin
      sat_seen = 1'b1;
      return 40'(SUM_LO);
    end
    return 40'(x);
  endfunction

  task automatic predict_cmd(input lma_pkg::cmd_t c);
    longint           acc;
    longint           src;
    longint           wgt;
    lma_pkg::result_t due;
    acc = longint'(unit_sum_q[c.dest_index]);
    wgt = longint'($signed(c.weight));
    case (c.mode)
      lma_pkg::MODE_CLEAR: unit_sum_q[c.dest_index] = '0;
      lma_pkg::MODE_SET_BIAS: unit_sum_q[c.dest_index] = 40'(wgt <<< 12);
      lma_pkg::MODE_ADD_BIAS: unit_sum_q[c.dest_index] = clamp_sum(acc + (wgt <<< 12));
      lma_pkg::MODE_ACCUM: begin
        if ((c.omit_flags & omit_mask_q) == '0) begin
          src = longint'($signed(c.source_value))
              + (offset_en_q ? longint'($signed(c.source_offset)) : longint'(0));
          unit_sum_q[c.dest_index] = clamp_sum(acc + src * wgt);
        end
      end
      lma_pkg::MODE_READ: begin
        due.unit_sum  = unit_sum_q[c.dest_index];
        due.saturated = sat_seen;
        reads_due.push_back(due);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    lma_pkg::result_t want;
    if (rst) begin
      foreach (unit_sum_q[i]) unit_sum_q[i] = '0;
      sat_seen      = 1'b0;
      omit_mask_q   = '0;
      offset_en_q   = 1'b0;
      reads_due.delete();
      errors        = 0;
      reads_checked = 0;
    end else begin
      if (done) begin
        if (reads_due.size() == 0) begin
          $error("unexpected result: unit_sum %0d saturated %0b",
                 result.unit_sum, result.saturated);
          errors++;
        end else begin
          want = reads_due.pop_front();
          reads_checked++;
          if (result.unit_sum !== want.unit_sum) begin
            $error("unit_sum mismatch: expected %0d, got %0d", want.unit_sum, result.unit_sum);
            errors++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated mismatch: expected %0b, got %0b",
                   want.saturated, result.saturated);
            errors++;
          end
        end
      end
      if (start && !busy) predict_cmd(cmd);
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            ADDR_OMIT_MASK: omit_mask_q = pwdata[15:0];
            ADDR_OFFSET_EN: offset_en_q = pwdata[0];
            default: ;
          endcase
        end else begin
          case (paddr)
            ADDR_OMIT_MASK: begin
              if (prdata[15:0] !== omit_mask_q) begin
                $error("omit_mask mismatch: expected %0h, got %0h", omit_mask_q, prdata[15:0]);
                errors++;
              end
            end
            ADDR_OFFSET_EN: begin
              if (prdata[0] !== offset_en_q) begin
                $error("offset_enable mismatch: expected %0b, got %0b", offset_en_q, prdata[0]);
                errors++;
              end
            end
            default: ;
          endcase
        end
      end
    end
    pending = reads_due.size();
  end

endmodule

[dv/tb.sv]
// testbench top for layer_mac_accumulator_core: clock, reset, command and apb stimulus
// depends on lma_pkg, layer_mac_accumulator_core and lma_sum_checker
`timescale 1ns / 1ps

module tb;

  localparam logic [2:0] ADDR_OMIT_MASK = {lma_pkg::REG_OMIT_MASK, 2'b00};
  localparam logic [2:0] ADDR_OFFSET_EN = {lma_pkg::REG_OFFSET_EN, 2'b00};
  localparam logic [15:0] Q_MAX = 16'h7FFF;
  localparam logic [15:0] Q_MIN = 16'h8000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  lma_pkg::cmd_t    cmd_in;
  logic             done;
  lma_pkg::result_t result;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int               errors;
  int               pending;
  int               reads_checked;

  bit unit_live [256];
  int idle_pct;
  int phase_cmds;
  int mode_count [8];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  layer_mac_accumulator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd_in), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lma_sum_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd_in), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .errors(errors),
    .pending(pending), .reads_checked(reads_checked)
  );

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [15:0] pick_q412();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_omit();
    return ($urandom_range(9) < 7) ? 16'h0000 : 16'($urandom);
  endfunction

  task automatic send(input logic [2:0] mode, input logic [7:0] dest, input logic [15:0] val,
                      input logic [15:0] off, input logic [15:0] wgt, input logic [15:0] omit);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start                 <= 1'b1;
    cmd_in.mode          <= mode;
    cmd_in.dest_index    <= dest;
    cmd_in.source_value  <= val;
    cmd_in.source_offset <= off;
    cmd_in.weight        <= wgt;
    cmd_in.omit_flags    <= omit;
    do @(posedge clk); while (busy);
    if (mode == lma_pkg::MODE_CLEAR || mode == lma_pkg::MODE_SET_BIAS) unit_live[dest] = 1'b1;
    mode_count[mode]++;
    if (mode <= lma_pkg::MODE_READ) phase_cmds++;
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] mask, input logic offs, input int pct);
    drain(4);
    apb_access(1'b1, ADDR_OMIT_MASK, {16'h0000, mask});
    apb_access(1'b1, ADDR_OFFSET_EN, {31'd0, offs});
    apb_access(1'b0, ADDR_OMIT_MASK, 32'($urandom));
    apb_access(1'b0, ADDR_OFFSET_EN, 32'($urandom));
    idle_pct = pct;
  endtask

  // bias or clear, a run of connections with occasional bias adds, then read back
  task automatic dot_product_seq();
    logic [7:0] d;
    int         n;
    d = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    if ($urandom_range(1))
      send(lma_pkg::MODE_CLEAR, d, pick_q412(), pick_q412(), pick_q412(), 16'($urandom));
    else
      send(lma_pkg::MODE_SET_BIAS, d, pick_q412(), pick_q412(), pick_q412(), 16'($urandom));
    n = $urandom_range(1, 24);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send(lma_pkg::MODE_ADD_BIAS, d, pick_q412(), pick_q412(), pick_q412(), 16'($urandom));
      else
        send(lma_pkg::MODE_ACCUM, d, pick_q412(), pick_q412(), pick_q412(), pick_omit());
    end
    send(lma_pkg::MODE_READ, d, pick_q412(), pick_q412(), pick_q412(), 16'($urandom));
  endtask

  task automatic noise_cmd();
    logic [2:0] mode;
    logic [7:0] d;
    mode = 3'($urandom_range(7));
    d    = 8'($urandom_range(255));
    if ((mode == lma_pkg::MODE_ADD_BIAS || mode == lma_pkg::MODE_ACCUM ||
         mode == lma_pkg::MODE_READ) && !unit_live[d])
      mode = $urandom_range(1) ? lma_pkg::MODE_CLEAR : lma_pkg::MODE_SET_BIAS;
    send(mode, d, pick_q412(), pick_q412(), pick_q412(), 16'($urandom));
  endtask

  // drive one unit past full scale, then bump it again with a bias
  task automatic saturate_unit(input bit up);
    logic [7:0]  d;
    logic [15:0] w;
    d = 8'($urandom_range(16, 31));
    w = up ? Q_MAX : Q_MIN;
    send(lma_pkg::MODE_SET_BIAS, d, 16'($urandom), 16'($urandom), w, 16'($urandom));
    repeat (264) send(lma_pkg::MODE_ACCUM, d, Q_MAX, Q_MAX, w, 16'h0000);
    send(lma_pkg::MODE_READ, d, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    send(lma_pkg::MODE_ADD_BIAS, d, 16'($urandom), 16'($urandom), w, 16'($urandom));
    send(lma_pkg::MODE_READ, d, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic run_random(input int budget);
    phase_cmds = 0;
    while (phase_cmds < budget) begin
      if ($urandom_range(3) != 0) dot_product_seq();
      else noise_cmd();
    end
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    cmd_in   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(16'h00F0, 1'b1, 0);
    send(lma_pkg::MODE_CLEAR, 8'd0, 16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF);
    send(lma_pkg::MODE_READ, 8'd0, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(lma_pkg::MODE_SET_BIAS, 8'd1, 16'($urandom), 16'($urandom), Q_MAX, 16'($urandom));
    send(lma_pkg::MODE_SET_BIAS, 8'd2, 16'($urandom), 16'($urandom), Q_MIN, 16'($urandom));
    send(lma_pkg::MODE_READ, 8'd1, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(lma_pkg::MODE_READ, 8'd2, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(lma_pkg::MODE_ADD_BIAS, 8'd1, 16'($urandom), 16'($urandom), Q_MAX, 16'hFFFF);
    send(lma_pkg::MODE_READ, 8'd1, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(lma_pkg::MODE_ACCUM, 8'd0, Q_MIN, Q_MIN, Q_MIN, 16'h0000);
    send(lma_pkg::MODE_ACCUM, 8'd0, Q_MAX, Q_MAX, Q_MIN, 16'h0010);
    send(lma_pkg::MODE_ACCUM, 8'd0, Q_MAX, 16'h0000, Q_MAX, 16'hFF0F);
    send(lma_pkg::MODE_READ, 8'd0, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(3'd5, 8'd0, Q_MAX, Q_MAX, Q_MAX, 16'h0000);
    send(3'd6, 8'd0, Q_MIN, Q_MIN, Q_MIN, 16'h0000);
    send(3'd7, 8'd0, Q_MAX, Q_MAX, Q_MAX, 16'h0000);
    send(lma_pkg::MODE_READ, 8'd0, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(lma_pkg::MODE_CLEAR, 8'd255, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));
    send(lma_pkg::MODE_ACCUM, 8'd255, 16'hFFFF, 16'h0001, Q_MAX, 16'h0000);
    send(lma_pkg::MODE_ADD_BIAS, 8'd255, 16'($urandom), 16'($urandom), Q_MIN,
         16'($urandom));
    send(lma_pkg::MODE_READ, 8'd255, 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom));

    set_config(16'h0000, 1'b0, 0);
    run_random(220);
    set_config(16'hFFFF, 1'b1, 62);
    saturate_unit(1'b1);
    run_random(220);
    set_config(16'($urandom), 1'b1, 0);
    saturate_unit(1'b0);
    run_random(220);
    set_config(16'($urandom), 1'b0, 31);
    run_random(220);
    set_config(16'h0000, 1'b1, 0);
    run_random(220);

    drain(8);
    $display("tb: commands sent: clear %0d, set %0d, add %0d, accumulate %0d, read %0d, unused %0d",
             mode_count[lma_pkg::MODE_CLEAR], mode_count[lma_pkg::MODE_SET_BIAS],
             mode_count[lma_pkg::MODE_ADD_BIAS], mode_count[lma_pkg::MODE_ACCUM],
             mode_count[lma_pkg::MODE_READ],
             mode_count[5] + mode_count[6] + mode_count[7]);
    $display("tb: %0d read results compared over 6 register settings, %0d errors",
             reads_checked, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/lma_pkg.sv
design/lma_cfg_regs.sv
design/lma_sum_mem.sv
design/lma_mac_unit.sv
design/layer_mac_accumulator_core.sv
dv/lma_sum_checker.sv
dv/tb.sv
